/* rtl/ypp_pkg.sv */
// ----------------------------------------------------------------------------
// ypp_pkg
// Shared widths, codes and helpers of the yaw/pitch point projector.
// ----------------------------------------------------------------------------
package ypp_pkg;

    // coordinate and trig formats
    localparam int CW  = 32;
    localparam int TW  = 16;
    localparam int CFB = 16;
    localparam int TFB = 14;
    localparam int ZFB = 8;

    // configuration address width (eight 32-bit registers)
    localparam int AW = 5;

    // short-direction threshold in LSB
    localparam int DIR_MIN_LEN = (1 << CFB) / 10000;

    // item kinds
    typedef enum logic [1:0] {
        KIND_SCREEN_PT = 2'd0,
        KIND_VIEW_VEC  = 2'd1,
        KIND_UNIT_DIR  = 2'd2,
        KIND_VIEW_PT   = 2'd3
    } t_kind;

    // register indexes
    typedef enum logic [2:0] {
        REG_COS_AZ  = 3'd0,
        REG_SIN_AZ  = 3'd1,
        REG_COS_EL  = 3'd2,
        REG_SIN_EL  = 3'd3,
        REG_Z_SCALE = 3'd4,
        REG_ORG_X   = 3'd5,
        REG_ORG_Y   = 3'd6,
        REG_SCALE   = 3'd7
    } t_reg;

    // side data carried beside the square root and divide stages
    typedef struct packed {
        logic                 is_dir;
        logic signed [CW-1:0] res_x;
        logic signed [CW-1:0] res_y;
        logic signed [CW-1:0] res_d;
        logic [CW-1:0]        mag_x;
        logic [CW-1:0]        mag_y;
        logic                 neg_x;
        logic                 neg_y;
    } t_aux;

    // saturate to 32-bit two's complement
    function automatic logic signed [CW-1:0] f_sat(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage

/* rtl/ypp_if.sv */
// ----------------------------------------------------------------------------
// ypp channel interfaces
// Valid/ready channels for input points and projected results.
// ----------------------------------------------------------------------------
interface ypp_pt_if;
    import ypp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    modport source (output valid, kind, in_x, in_y, in_z, input ready);
    modport sink   (input valid, kind, in_x, in_y, in_z, output ready);
endinterface

interface ypp_res_if;
    import ypp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_depth;
    logic                 direction_ok;
    modport source (output valid, out_x, out_y, out_depth, direction_ok, input ready);
    modport sink   (input valid, out_x, out_y, out_depth, direction_ok, output ready);
endinterface

/* rtl/yaw_pitch_point_projector_top.sv */
// ----------------------------------------------------------------------------
// yaw_pitch_point_projector_top
// Rotates a point by azimuth then elevation and maps it to screen, view or
// unit-direction form, in a single stalling pipeline.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the whole pipe holds while the output
//   register is full and not taken
// depth is set by the 32-step square root and 17-step divide chains
// reset (synchronous, active low) empties the pipe and loads register defaults
module yaw_pitch_point_projector_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ypp_pkg::AW-1:0]  paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    ypp_pt_if.sink                  i_pt,
    ypp_res_if.source               o_res
);
    import ypp_pkg::*;

    localparam int PW    = CW + TW;          // first products
    localparam int XAW   = PW + 1 - TFB;     // azimuth rotated x/y
    localparam int ZSW   = PW - ZFB;         // scaled z
    localparam int MW    = TW + ZSW;         // elevation products
    localparam int VW    = MW + 1 - TFB;     // elevation sums
    localparam int SW    = 64 - CFB;         // scaled screen offset
    localparam int SQ_N  = CW;               // square root steps
    localparam int QB    = CFB + 1;          // quotient bits
    localparam int NW    = CW + CFB;         // dividend width
    localparam int RND_T = 1 << (TFB - 1);
    localparam int RND_Z = 1 << (ZFB - 1);
    localparam int RND_C = 1 << (CFB - 1);
    localparam int ONE_Q = 1 << CFB;
    localparam logic signed [TW-1:0] ZS_UNITY = TW'(1 << ZFB);

    // configuration registers
    logic signed [TW-1:0] r_cos_az, r_sin_az, r_cos_el, r_sin_el, r_z_scale;
    logic signed [CW-1:0] r_org_x, r_org_y;
    logic [CW-2:0]        r_scale;
    logic                 w_wr;
    t_reg                 w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg'(paddr[AW-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_az  <= TW'(1 << TFB);
            r_sin_az  <= '0;
            r_cos_el  <= TW'(1 << TFB);
            r_sin_el  <= '0;
            r_z_scale <= ZS_UNITY;
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_scale   <= (CW-1)'(ONE_Q);
        end else if (w_wr) begin
            case (w_idx)
                REG_COS_AZ:  r_cos_az  <= pwdata[TW-1:0];
                REG_SIN_AZ:  r_sin_az  <= pwdata[TW-1:0];
                REG_COS_EL:  r_cos_el  <= pwdata[TW-1:0];
                REG_SIN_EL:  r_sin_el  <= pwdata[TW-1:0];
                REG_Z_SCALE: r_z_scale <= pwdata[TW-1:0];
                REG_ORG_X:   r_org_x   <= pwdata;
                REG_ORG_Y:   r_org_y   <= pwdata;
                REG_SCALE:   r_scale   <= pwdata[CW-2:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            REG_COS_AZ:  prdata = 32'(r_cos_az);
            REG_SIN_AZ:  prdata = 32'(r_sin_az);
            REG_COS_EL:  prdata = 32'(r_cos_el);
            REG_SIN_EL:  prdata = 32'(r_sin_el);
            REG_Z_SCALE: prdata = 32'(r_z_scale);
            REG_ORG_X:   prdata = r_org_x;
            REG_ORG_Y:   prdata = r_org_y;
            REG_SCALE:   prdata = {1'b0, r_scale};
            default:     prdata = '0;
        endcase
    end

    // pipe advance
    logic w_en;
    logic r_out_vld;
    assign w_en       = !r_out_vld || o_res.ready;
    assign i_pt.ready = w_en;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [1:0] r_k1, r_k2, r_k3, r_k4, r_k5;

    // stage 1: azimuth and z products
    logic signed [PW-1:0] r_p_cx, r_p_sy, r_p_sx, r_p_cy, r_p_zz;
    logic signed [TW-1:0] w_zmul;
    assign w_zmul = (i_pt.kind == KIND_VIEW_VEC) ? ZS_UNITY : r_z_scale;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k1   <= i_pt.kind;
            r_p_cx <= i_pt.in_x * r_cos_az;
            r_p_sy <= i_pt.in_y * r_sin_az;
            r_p_sx <= i_pt.in_x * r_sin_az;
            r_p_cy <= i_pt.in_y * r_cos_az;
            r_p_zz <= i_pt.in_z * w_zmul;
        end
    end

    // stage 2: azimuth sums and rounding
    logic signed [PW:0]    w_sxa, w_sya;
    logic signed [PW-1:0]  w_szs;
    logic signed [XAW-1:0] r_xa, r_ya;
    logic signed [ZSW-1:0] r_zs;
    assign w_sxa = (PW+1)'(r_p_cx) - (PW+1)'(r_p_sy) + (PW+1)'(RND_T);
    assign w_sya = (PW+1)'(r_p_sx) + (PW+1)'(r_p_cy) + (PW+1)'(RND_T);
    assign w_szs = r_p_zz + PW'(RND_Z);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k2 <= r_k1;
            r_xa <= w_sxa[PW:TFB];
            r_ya <= w_sya[PW:TFB];
            r_zs <= w_szs[PW-1:ZFB];
        end
    end

    // stage 3: elevation products
    logic signed [MW-1:0] r_m_cy, r_m_sz, r_m_sy, r_m_cz;
    logic signed [CW-1:0] r_vx3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k3   <= r_k2;
            r_m_cy <= r_ya * r_cos_el;
            r_m_sz <= r_zs * r_sin_el;
            r_m_sy <= r_ya * r_sin_el;
            r_m_cz <= r_zs * r_cos_el;
            r_vx3  <= f_sat(64'(r_xa));
        end
    end

    // stage 4: elevation sums, rounding, saturation
    logic signed [MW:0]   w_svy, w_svz;
    logic signed [CW-1:0] r_vx4, r_vy4, r_vz4;
    assign w_svy = (MW+1)'(r_m_cy) - (MW+1)'(r_m_sz) + (MW+1)'(RND_T);
    assign w_svz = (MW+1)'(r_m_sy) + (MW+1)'(r_m_cz) + (MW+1)'(RND_T);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k4  <= r_k3;
            r_vx4 <= r_vx3;
            r_vy4 <= f_sat(64'(signed'(w_svy[MW:TFB])));
            r_vz4 <= f_sat(64'(signed'(w_svz[MW:TFB])));
        end
    end

    // stage 5: screen scale products and squares
    logic signed [63:0]   r_px, r_py, r_qx, r_qy;
    logic signed [CW-1:0] r_vx5, r_vy5, r_vz5;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k5  <= r_k4;
            r_vx5 <= r_vx4;
            r_vy5 <= r_vy4;
            r_vz5 <= r_vz4;
            r_px  <= r_vx4 * signed'({1'b0, r_scale});
            r_py  <= r_vy4 * signed'({1'b0, r_scale});
            r_qx  <= r_vx4 * r_vx4;
            r_qy  <= r_vy4 * r_vy4;
        end
    end

    // stage 6: screen mapping, squared length, direction magnitudes
    logic signed [63:0]   w_rpx, w_rpy;
    logic signed [SW:0]   w_ox, w_oy;
    t_aux                 w_aux;
    assign w_rpx = r_px + 64'(RND_C);
    assign w_rpy = r_py + 64'(RND_C);
    assign w_ox  = (SW+1)'(r_org_x) + (SW+1)'(signed'(w_rpx[63:CFB]));
    assign w_oy  = (SW+1)'(r_org_y) - (SW+1)'(signed'(w_rpy[63:CFB]));

    always_comb begin
        w_aux.is_dir = (r_k5 == KIND_UNIT_DIR);
        if (r_k5 == KIND_SCREEN_PT) begin
            w_aux.res_x = f_sat(64'(w_ox));
            w_aux.res_y = f_sat(64'(w_oy));
        end else begin
            w_aux.res_x = r_vx5;
            w_aux.res_y = r_vy5;
        end
        w_aux.res_d = r_vz5;
        w_aux.neg_x = r_vx5[CW-1];
        w_aux.mag_x = r_vx5[CW-1] ? -r_vx5 : r_vx5;
        w_aux.neg_y = !r_vy5[CW-1] && (r_vy5 != '0);
        w_aux.mag_y = r_vy5[CW-1] ? -r_vy5 : r_vy5;
    end

    // square root chain, one result bit per stage
    logic         r_sq_vld  [0:SQ_N];
    t_aux         r_sq_aux  [0:SQ_N];
    logic [63:0]  r_sq_val  [0:SQ_N];
    logic [CW-1:0] r_sq_root[0:SQ_N];
    logic [CW+1:0] r_sq_rem [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_aux[0]  <= w_aux;
            r_sq_val[0]  <= {1'b0, r_qx[62:0]} + {1'b0, r_qy[62:0]};
            r_sq_root[0] <= '0;
            r_sq_rem[0]  <= '0;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [CW+1:0] w_rem2, w_trial;
        assign w_rem2  = {r_sq_rem[k][CW-1:0], r_sq_val[k][63-2*k -: 2]};
        assign w_trial = {r_sq_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_aux[k+1] <= r_sq_aux[k];
                r_sq_val[k+1] <= r_sq_val[k];
                if (w_rem2 >= w_trial) begin
                    r_sq_rem[k+1]  <= w_rem2 - w_trial;
                    r_sq_root[k+1] <= {r_sq_root[k][CW-2:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= w_rem2;
                    r_sq_root[k+1] <= {r_sq_root[k][CW-2:0], 1'b0};
                end
            end
        end
    end

    // divide setup: rounded dividends, top quotient bits known zero
    logic          r_dv_vld [0:QB];
    t_aux          r_dv_aux [0:QB];
    logic          r_dv_ok  [0:QB];
    logic [CW-1:0] r_dv_len [0:QB];
    logic [NW-1:0] r_dv_nx  [0:QB];
    logic [NW-1:0] r_dv_ny  [0:QB];
    logic [CW-1:0] r_dv_rx  [0:QB];
    logic [CW-1:0] r_dv_ry  [0:QB];
    logic [QB-1:0] r_dv_qx  [0:QB];
    logic [QB-1:0] r_dv_qy  [0:QB];
    logic [CW-1:0] w_len;
    logic [NW-1:0] w_nx, w_ny;
    assign w_len = r_sq_root[SQ_N];
    assign w_nx  = {r_sq_aux[SQ_N].mag_x, CFB'(0)} + NW'(w_len >> 1);
    assign w_ny  = {r_sq_aux[SQ_N].mag_y, CFB'(0)} + NW'(w_len >> 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_aux[0] <= r_sq_aux[SQ_N];
            r_dv_ok[0]  <= w_len > CW'(DIR_MIN_LEN);
            r_dv_len[0] <= w_len;
            r_dv_nx[0]  <= w_nx;
            r_dv_ny[0]  <= w_ny;
            r_dv_rx[0]  <= CW'(w_nx[NW-1:QB]);
            r_dv_ry[0]  <= CW'(w_ny[NW-1:QB]);
            r_dv_qx[0]  <= '0;
            r_dv_qy[0]  <= '0;
        end
    end

    // restoring divide, one quotient bit per stage for each axis
    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [CW:0] w_r2x, w_r2y, w_dfx, w_dfy;
        assign w_r2x = {r_dv_rx[j], r_dv_nx[j][QB-1-j]};
        assign w_r2y = {r_dv_ry[j], r_dv_ny[j][QB-1-j]};
        assign w_dfx = w_r2x - {1'b0, r_dv_len[j]};
        assign w_dfy = w_r2y - {1'b0, r_dv_len[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_aux[j+1] <= r_dv_aux[j];
                r_dv_ok[j+1]  <= r_dv_ok[j];
                r_dv_len[j+1] <= r_dv_len[j];
                r_dv_nx[j+1]  <= r_dv_nx[j];
                r_dv_ny[j+1]  <= r_dv_ny[j];
                if (w_r2x >= {1'b0, r_dv_len[j]}) begin
                    r_dv_rx[j+1] <= w_dfx[CW-1:0];
                    r_dv_qx[j+1] <= {r_dv_qx[j][QB-2:0], 1'b1};
                end else begin
                    r_dv_rx[j+1] <= w_r2x[CW-1:0];
                    r_dv_qx[j+1] <= {r_dv_qx[j][QB-2:0], 1'b0};
                end
                if (w_r2y >= {1'b0, r_dv_len[j]}) begin
                    r_dv_ry[j+1] <= w_dfy[CW-1:0];
                    r_dv_qy[j+1] <= {r_dv_qy[j][QB-2:0], 1'b1};
                end else begin
                    r_dv_ry[j+1] <= w_r2y[CW-1:0];
                    r_dv_qy[j+1] <= {r_dv_qy[j][QB-2:0], 1'b0};
                end
            end
        end
    end

    // valid bits of the front stages, the chain inputs and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_sq_vld[0] <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_out_vld   <= 1'b0;
        end else if (w_en) begin
            r_v1        <= i_pt.valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_sq_vld[0] <= r_v5;
            r_dv_vld[0] <= r_sq_vld[SQ_N];
            r_out_vld   <= r_dv_vld[QB];
        end
    end

    // output register: pick direction or carried results, or zeros for a short direction
    logic signed [CW-1:0] r_out_x, r_out_y, r_out_d;
    logic                 r_out_ok;
    logic signed [CW-1:0] w_ux, w_uy;
    assign w_ux = r_dv_aux[QB].neg_x ? -CW'(r_dv_qx[QB]) : CW'(r_dv_qx[QB]);
    assign w_uy = r_dv_aux[QB].neg_y ? -CW'(r_dv_qy[QB]) : CW'(r_dv_qy[QB]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_dv_aux[QB].is_dir) begin
                r_out_x  <= r_dv_aux[QB].res_x;
                r_out_y  <= r_dv_aux[QB].res_y;
                r_out_d  <= r_dv_aux[QB].res_d;
                r_out_ok <= 1'b1;
            end else if (r_dv_ok[QB]) begin
                r_out_x  <= w_ux;
                r_out_y  <= w_uy;
                r_out_d  <= '0;
                r_out_ok <= 1'b1;
            end else begin
                r_out_x  <= '0;
                r_out_y  <= '0;
                r_out_d  <= '0;
                r_out_ok <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.out_x        = r_out_x;
    assign o_res.out_y        = r_out_y;
    assign o_res.out_depth    = r_out_d;
    assign o_res.direction_ok = r_out_ok;

    // a short direction gives an all-zero item
    a_short_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.direction_ok |->
            o_res.out_x == '0 && o_res.out_y == '0 && o_res.out_depth == '0)
        else $error("short direction item not zero");

    // a stalled output freezes the deep stages
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=>
            $stable(r_sq_vld[SQ_N]) && $stable(r_dv_vld[QB]) && $stable(r_dv_qx[QB]))
        else $error("pipe moved during stall");

    // square root remainder stays within twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld[SQ_N] |-> r_sq_rem[SQ_N] <= (CW+2)'({r_sq_root[SQ_N], 1'b0}))
        else $error("square root remainder out of range");

    // unit quotients never exceed one
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[QB] && r_dv_aux[QB].is_dir && r_dv_ok[QB] |->
            r_dv_qx[QB] <= QB'(ONE_Q) && r_dv_qy[QB] <= QB'(ONE_Q))
        else $error("unit quotient above one");

endmodule
